### src/dmfb_pkg.sv
// shared types and constants for the dual monochrome frame buffer
package dmfb_pkg;

    // request codes carried on the input tuser
    typedef enum logic [3:0] {
        REQ_RDBYTE  = 4'd0,
        REQ_WRBYTE  = 4'd1,
        REQ_SETPIX  = 4'd2,
        REQ_GETPIX  = 4'd3,
        REQ_COPY    = 4'd4,
        REQ_CLRTEMP = 4'd5,
        REQ_OR      = 4'd6,
        REQ_ANDNOT  = 4'd7,
        REQ_FILL    = 4'd8
    } t_req;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_END,
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic rd_en;      // register both memory read ports
        logic rd_sweep;   // read address from sweep counter
        logic capture;    // latch the accepted request
        logic acc_wr;     // single byte or pixel write-back
        logic sweep_run;  // advance sweep counter
        logic init;       // sweep clears both buffers
        logic load_out;   // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_last;   // sweep counter at last address
    } t_sts;

    localparam logic [7:0] PIX_MASK_LSB = 8'h01;
    localparam int PIX_PER_PAGE_LOG2 = 3;

endpackage

### src/dmfb_ctrl.sv
// controller state machine for the dual monochrome frame buffer
module dmfb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [3:0]            i_req_type,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output dmfb_pkg::t_cmd        o_cmd,
    input  dmfb_pkg::t_sts        i_sts
);
    import dmfb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;
    t_req   req;

    assign out_free    = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign req         = t_req'(i_req_type);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep_run = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sweep  = 1'b1;
                o_cmd.init      = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_INIT_END;
                end
            end
            ST_INIT_END: begin
                o_cmd.init = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    if (req inside {REQ_COPY, REQ_CLRTEMP, REQ_OR, REQ_ANDNOT, REQ_FILL}) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                // write-back repeats the same value while waiting, so it is harmless
                o_cmd.acc_wr = 1'b1;
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sweep  = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_ACCESS || r_state == ST_SWEEP))
        else $error("accepted request not dispatched");

    a_sweep_ends_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP_END) |-> $past(i_sts.cnt_last))
        else $error("sweep ended before last address");

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT || r_state == ST_INIT_END) |-> !o_in_ready)
        else $error("request accepted during clearing pass");
`endif

endmodule

### src/dmfb_dp.sv
// datapath with screen and temp memories, sweep counter and result register
module dmfb_dp #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic [3:0]            i_req_type,
    input  logic [2:0]            i_page,
    input  logic [6:0]            i_column,
    input  logic [5:0]            i_row,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_pixel_on,
    output logic [7:0]            o_read_byte,
    output logic                  o_pixel_bit,
    input  dmfb_pkg::t_cmd        i_cmd,
    output dmfb_pkg::t_sts        o_sts
);
    import dmfb_pkg::*;

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = 12;

    logic [7:0]    r_screen [DEPTH];
    logic [7:0]    r_temp   [DEPTH];

    logic          r_sel;
    t_req          r_type;
    logic [AW-1:0] r_addr;
    logic          r_ok;
    logic [2:0]    r_bit;
    logic [7:0]    r_data;
    logic          r_on;
    logic [7:0]    r_rd_scr, r_rd_tmp;
    logic [AW-1:0] r_cnt, r_wa;
    logic          r_wv;
    logic [7:0]    r_read_byte;
    logic          r_pixel_bit;

    t_req          in_type;
    logic [2:0]    in_pg;
    logic [LW-1:0] in_lin;
    logic [AW-1:0] in_addr;
    logic          in_ok;
    logic [AW-1:0] rd_addr;
    logic          cnt_last;
    logic [7:0]    sel_byte, mask, acc_byte;
    logic          acc_we;
    logic          scr_we, tmp_we;
    logic [AW-1:0] scr_wa, tmp_wa;
    logic [7:0]    scr_wd, tmp_wd;
    logic [7:0]    res_byte;
    logic          res_bit;

    // byte requests address by page, pixel requests by row / 8
    always_comb begin
        in_type = t_req'(i_req_type);
        if (in_type == REQ_SETPIX || in_type == REQ_GETPIX) begin
            in_pg = i_row[5:PIX_PER_PAGE_LOG2];
        end else begin
            in_pg = i_page;
        end
        in_lin  = LW'(in_pg) * LW'(COLUMNS) + LW'(i_column);
        in_addr = in_lin[AW-1:0];
        in_ok   = (int'(in_pg) < PAGES) && (int'(i_column) < COLUMNS);
    end

    assign cnt_last     = (r_cnt == AW'(DEPTH - 1));
    assign o_sts.cnt_last = cnt_last;
    assign rd_addr      = i_cmd.rd_sweep ? r_cnt : in_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b1;
            r_cnt <= '0;
            r_wv  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sel <= i_cfg_wdata;
            end
            r_wv <= i_cmd.sweep_run;
            if (i_cmd.sweep_run) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= r_cnt;
        if (i_cmd.capture) begin
            r_type <= in_type;
            r_addr <= in_addr;
            r_ok   <= in_ok;
            r_bit  <= i_row[2:0];
            r_data <= i_data_byte;
            r_on   <= i_pixel_on;
        end
        if (i_cmd.load_out) begin
            r_read_byte <= res_byte;
            r_pixel_bit <= res_bit;
        end
    end

    // single access read-modify-write
    always_comb begin
        sel_byte = r_sel ? r_rd_scr : r_rd_tmp;
        mask     = PIX_MASK_LSB << r_bit;
        if (r_type == REQ_WRBYTE) begin
            acc_byte = r_data;
        end else if (r_on) begin
            acc_byte = sel_byte | mask;
        end else begin
            acc_byte = sel_byte & ~mask;
        end
        acc_we   = i_cmd.acc_wr && r_ok && (r_type == REQ_WRBYTE || r_type == REQ_SETPIX);
        res_byte = (r_type == REQ_RDBYTE && r_ok) ? sel_byte : 8'd0;
        res_bit  = (r_type == REQ_GETPIX && r_ok) ? sel_byte[r_bit] : 1'b0;
    end

    // write port select: sweep write stage or single access
    always_comb begin
        scr_we = 1'b0;
        tmp_we = 1'b0;
        scr_wa = r_addr;
        tmp_wa = r_addr;
        scr_wd = acc_byte;
        tmp_wd = acc_byte;
        if (r_wv) begin
            scr_wa = r_wa;
            tmp_wa = r_wa;
            scr_wd = 8'd0;
            tmp_wd = 8'd0;
            if (i_cmd.init) begin
                scr_we = 1'b1;
                tmp_we = 1'b1;
            end else begin
                case (r_type)
                    REQ_COPY: begin
                        scr_we = 1'b1;
                        scr_wd = r_rd_tmp;
                    end
                    REQ_CLRTEMP: begin
                        tmp_we = 1'b1;
                    end
                    REQ_OR: begin
                        scr_we = 1'b1;
                        scr_wd = r_rd_scr | r_rd_tmp;
                    end
                    REQ_ANDNOT: begin
                        scr_we = 1'b1;
                        scr_wd = r_rd_scr & ~r_rd_tmp;
                    end
                    REQ_FILL: begin
                        scr_we = 1'b1;
                        scr_wd = r_data;
                    end
                    default: begin
                        scr_we = 1'b0;
                    end
                endcase
            end
        end else if (acc_we) begin
            scr_we = r_sel;
            tmp_we = !r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_screen[scr_wa] <= scr_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_scr <= r_screen[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tmp_we) begin
            r_temp[tmp_wa] <= tmp_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_tmp <= r_temp[rd_addr];
        end
    end

    assign o_read_byte = r_read_byte;
    assign o_pixel_bit = r_pixel_bit;

endmodule

### src/dual_mono_frame_buffer_unit.sv
// Dual monochrome frame buffer: byte and pixel access plus whole-buffer operations.
// Byte and pixel requests each do one memory read, then write-back and result.
// Whole-buffer requests sweep every address once.
// After reset a clearing pass zeroes both buffers; no request is taken meanwhile,
// but the select register can be written at any time.
// One request is worked at a time; the output register lets the next one in while it waits.
module dual_mono_frame_buffer_unit #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // buffer select register: 1 screen, 0 temp
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // page[2:0] column[9:3] row[15:10] data_byte[23:16]
                                       // pixel_on[24], zeros above
    input  logic [3:0]  s_axis_tuser,  // req_type[3:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // read_byte[7:0] pixel_bit[8], zeros above
);
    import dmfb_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] read_byte;
    logic       pixel_bit;

    // sequencing, handshakes and output valid
    dmfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // memories, addressing, sweep counter and result data
    dmfb_dp #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (s_axis_tuser),
        .i_page      (s_axis_tdata[2:0]),
        .i_column    (s_axis_tdata[9:3]),
        .i_row       (s_axis_tdata[15:10]),
        .i_data_byte (s_axis_tdata[23:16]),
        .i_pixel_on  (s_axis_tdata[24]),
        .o_read_byte (read_byte),
        .o_pixel_bit (pixel_bit),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // result packing, unused upper bits held at zero
    assign m_axis_tdata = {7'd0, pixel_bit, read_byte};

endmodule

### test/tb_top.sv
// self-checking testbench for the dual monochrome frame buffer unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmfb_pkg::*;

    localparam int FB_PAGES   = 8;
    localparam int FB_COLUMNS = 128;
    localparam int FB_BYTES   = FB_PAGES * FB_COLUMNS;

    // request codes past the defined set, answered with zeros
    localparam logic [3:0] REQ_UNKNOWN_FIRST = 4'd9;
    localparam logic [3:0] REQ_UNKNOWN_LAST  = 4'd15;

    // values of the buffer select register
    localparam bit SEL_TEMP   = 1'b0;
    localparam bit SEL_SCREEN = 1'b1;

    // even if every request swept all 1024 bytes the run would stay well below this
    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_AT = 150;

    typedef struct {
        logic [3:0] req_code;
        logic [2:0] page;
        logic [6:0] column;
        logic [5:0] row;
        logic [7:0] data_byte;
        logic       pixel_on;
    } fb_request_t;

    typedef struct {
        logic [7:0] read_byte;
        logic       pixel_bit;
    } fb_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    dual_mono_frame_buffer_unit #(
        .PAGES   (FB_PAGES),
        .COLUMNS (FB_COLUMNS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of both buffers and of the select register
    logic [7:0]  screen_img [FB_BYTES] = '{default: 8'h00};
    logic [7:0]  temp_img [FB_BYTES] = '{default: 8'h00};
    bit          sel_shadow = SEL_SCREEN;

    fb_request_t pending_requests [$];
    fb_result_t  readback_due [$];
    fb_request_t req_on_bus;
    int unsigned fail_count = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    // no random idling on either side while set
    bit          steady = 1'b0;

    // applies one request to the shadow buffers and returns the readback it yields
    function automatic fb_result_t predict_readback(fb_request_t rq);
        fb_result_t res;
        int         at_byte;
        int         at_pix;
        logic [7:0] mask;
        res.read_byte = 8'h00;
        res.pixel_bit = 1'b0;
        at_byte = int'(rq.page) * FB_COLUMNS + int'(rq.column);
        // pixel row: upper bits pick the page, low three bits the bit in the byte
        at_pix = int'(rq.row[5:3]) * FB_COLUMNS + int'(rq.column);
        mask = PIX_MASK_LSB << rq.row[2:0];
        case (rq.req_code)
            REQ_RDBYTE: begin
                res.read_byte = sel_shadow ? screen_img[at_byte] : temp_img[at_byte];
            end
            REQ_WRBYTE: begin
                if (sel_shadow) screen_img[at_byte] = rq.data_byte;
                else temp_img[at_byte] = rq.data_byte;
            end
            REQ_SETPIX: begin
                if (sel_shadow) begin
                    screen_img[at_pix] = rq.pixel_on ? (screen_img[at_pix] | mask)
                                                     : (screen_img[at_pix] & ~mask);
                end else begin
                    temp_img[at_pix] = rq.pixel_on ? (temp_img[at_pix] | mask)
                                                   : (temp_img[at_pix] & ~mask);
                end
            end
            REQ_GETPIX: begin
                res.pixel_bit = sel_shadow ? |(screen_img[at_pix] & mask)
                                           : |(temp_img[at_pix] & mask);
            end
            REQ_COPY: begin
                foreach (screen_img[i]) screen_img[i] = temp_img[i];
            end
            REQ_CLRTEMP: begin
                foreach (temp_img[i]) temp_img[i] = 8'h00;
            end
            REQ_OR: begin
                foreach (screen_img[i]) screen_img[i] = screen_img[i] | temp_img[i];
            end
            REQ_ANDNOT: begin
                foreach (screen_img[i]) screen_img[i] = screen_img[i] & ~temp_img[i];
            end
            REQ_FILL: begin
                foreach (screen_img[i]) screen_img[i] = rq.data_byte;
            end
            default: begin
                // unknown code: no change, zero result
            end
        endcase
        return res;
    endfunction

    function automatic fb_request_t make_request(logic [3:0] code, logic [2:0] page,
                                                 logic [6:0] column, logic [5:0] row,
                                                 logic [7:0] data_byte, logic pixel_on);
        fb_request_t rq;
        rq.req_code  = code;
        rq.page      = page;
        rq.column    = column;
        rq.row       = row;
        rq.data_byte = data_byte;
        rq.pixel_on  = pixel_on;
        return rq;
    endfunction

    // mostly byte and pixel traffic on a small hot area so reads find written data,
    // a few whole-buffer sweeps, some unknown codes and full-range coordinates
    function automatic fb_request_t random_request();
        fb_request_t rq;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 4) begin
            rq.req_code = 4'($urandom_range(REQ_FILL, REQ_COPY));
        end else if (pick < 7) begin
            rq.req_code = 4'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
        end else begin
            rq.req_code = 4'($urandom_range(REQ_GETPIX, REQ_RDBYTE));
        end
        rq.page      = 3'($urandom_range(7, 0));
        rq.data_byte = 8'($urandom_range(255, 0));
        rq.pixel_on  = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 75) begin
            // hot area: four columns at each edge, pixel row inside the chosen page
            rq.column = 7'($urandom_range(3, 0) + ($urandom_range(1, 0) ? 124 : 0));
            rq.row    = {rq.page, 3'($urandom_range(7, 0))};
        end else begin
            rq.column = 7'($urandom_range(127, 0));
            rq.row    = 6'($urandom_range(63, 0));
        end
        return rq;
    endfunction

    // driver: takes the next pending request unless idling, holds it until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                readback_due.push_back(predict_readback(req_on_bus));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // request still waiting, keep it on the bus
            end else if (pending_requests.size() != 0 &&
                         (steady || $urandom_range(99, 0) >= 9)) begin
                req_on_bus = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, req_on_bus.pixel_on, req_on_bus.data_byte,
                                  req_on_bus.row, req_on_bus.column, req_on_bus.page};
                s_axis_tuser  <= req_on_bus.req_code;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result against the oldest prediction and paces tready
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    fb_result_t  due;

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (readback_due.size() == 0) begin
                $error("result with no request outstanding: tdata %0h", m_axis_tdata);
                fail_count++;
            end else begin
                due = readback_due.pop_front();
                if (m_axis_tdata[7:0] !== due.read_byte) begin
                    $error("read_byte mismatch: expected %0h, actual %0h",
                           due.read_byte, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[8] !== due.pixel_bit) begin
                    $error("pixel_bit mismatch: expected %0b, actual %0b",
                           due.pixel_bit, m_axis_tdata[8]);
                    fail_count++;
                end
            end
            results_seen++;
        end
        // one long hold-off so the sender backs up against a full block
        if (!hold_done && results_seen == HOLD_OFF_AT) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || $urandom_range(99, 0) >= 9;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dual_mono_frame_buffer_unit regression: fail");
            $finish;
        end
    end

    // waits until nothing is queued, on the bus or outstanding; sampled at the falling
    // edge so the driver and monitor updates of the rising edge have settled
    task automatic drain();
        while (pending_requests.size() != 0 || s_axis_tvalid || readback_due.size() != 0)
            @(negedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic select_buffer(bit sel);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sel;
        sel_shadow = sel;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(bit sel, int unsigned count);
        select_buffer(sel);
        repeat (count) pending_requests.push_back(random_request());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // screen selected out of reset: fresh reads, edge coordinates, fill, unknown codes
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_GETPIX, 3'd7, 7'd127, 6'd63, 8'hff, 1'b1));
        pending_requests.push_back(make_request(REQ_WRBYTE, 3'd7, 7'd127, 6'd63, 8'hff, 1'b1));
        pending_requests.push_back(make_request(REQ_WRBYTE, 3'd0, 7'd0, 6'd0, 8'h5a, 1'b0));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd7, 7'd127, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_SETPIX, 3'd0, 7'd0, 6'd63, 8'h00, 1'b1));
        pending_requests.push_back(make_request(REQ_GETPIX, 3'd0, 7'd0, 6'd63, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_SETPIX, 3'd0, 7'd127, 6'd56, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd7, 7'd127, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_FILL, 3'd0, 7'd0, 6'd0, 8'hff, 1'b0));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_UNKNOWN_FIRST, 3'd7, 7'd127, 6'd63,
                                                8'hff, 1'b1));
        pending_requests.push_back(make_request(REQ_UNKNOWN_LAST, 3'd0, 7'd0, 6'd0,
                                                8'h00, 1'b0));

        // temp selected: build temp content, then the OR, ANDNOT, COPY and clear-temp operations
        select_buffer(SEL_TEMP);
        pending_requests.push_back(make_request(REQ_WRBYTE, 3'd3, 7'd64, 6'd0, 8'hc3, 1'b0));
        pending_requests.push_back(make_request(REQ_SETPIX, 3'd0, 7'd5, 6'd0, 8'h00, 1'b1));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd3, 7'd64, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_GETPIX, 3'd0, 7'd5, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_OR, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_ANDNOT, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_COPY, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_CLRTEMP, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd3, 7'd64, 6'd0, 8'h00, 1'b0));

        // back to screen: copied data visible, then filled with zeros
        select_buffer(SEL_SCREEN);
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd3, 7'd64, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_FILL, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(REQ_RDBYTE, 3'd3, 7'd64, 6'd0, 8'h00, 1'b0));

        // random traffic; the long receiver hold-off falls in the first phase
        random_phase(SEL_TEMP, 300);
        drain();
        steady = 1'b1;
        random_phase(SEL_SCREEN, 300);
        drain();
        steady = 1'b0;
        random_phase(SEL_TEMP, 150);
        random_phase(SEL_SCREEN, 150);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && readback_due.size() == 0) begin
            $display("dual_mono_frame_buffer_unit regression: pass");
        end else begin
            $display("dual_mono_frame_buffer_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
src/dmfb_pkg.sv
src/dmfb_ctrl.sv
src/dmfb_dp.sv
src/dual_mono_frame_buffer_unit.sv
test/tb_top.sv
